>>> rtl/fhtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhtp_pkg
// Shared types, token codes and fixed-Huffman tables for the token packer.
// ----------------------------------------------------------------------------
package fhtp_pkg;

    localparam logic [1:0] OP_LIT   = 2'd0;
    localparam logic [1:0] OP_MATCH = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Longest token: header 3 + length code 8 + extra 5 + distance code 5 + extra 13
    localparam int WORD_W  = 34;
    localparam int NBITS_W = 6;
    // Up to seven leftover bits plus one whole token
    localparam int ACC_W   = WORD_W + 7;
    localparam int ACNT_W  = 6;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int LEN_N  = 29;
    localparam int DIST_N = 30;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  literal_byte;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
    } tok_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       stream_done;
    } res_t;

    // Token after classification, codes already bit-reversed for LSB-first packing
    typedef struct packed {
        logic        hdr;
        logic [8:0]  sym_rev;
        logic [3:0]  sym_n;
        logic [4:0]  lext;
        logic [2:0]  lext_n;
        logic        has_dist;
        logic [4:0]  dcode_rev;
        logic [12:0] dext;
        logic [3:0]  dext_n;
        logic        flush;
    } cls_t;

    // Queue entry: packed bit string, its length and the end-of-block mark
    typedef struct packed {
        logic [WORD_W-1:0]  bits;
        logic [NBITS_W-1:0] nbits;
        logic               flush;
    } ent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [8:0] LEN_BASE [LEN_N] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
    localparam logic [2:0] LEN_EXTRA [LEN_N] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
    localparam logic [15:0] DIST_BASE [DIST_N] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
        16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
        16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577};
    localparam logic [3:0] DIST_EXTRA [DIST_N] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

    function automatic logic [8:0] rev9(input logic [8:0] v);
        logic [8:0] r;
        for (int i = 0; i < 9; i++)
        begin
            r[i] = v[8-i];
        end
        return r;
    endfunction

    function automatic logic [4:0] rev5(input logic [4:0] v);
        logic [4:0] r;
        for (int i = 0; i < 5; i++)
        begin
            r[i] = v[4-i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/fhtp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhtp_front
// Accepts tokens, maps them to fixed-Huffman codes and extra bits, and packs
// each into one LSB-first bit string for the queue.
// ----------------------------------------------------------------------------
module fhtp_front
    import fhtp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic tok_valid,
    output logic      tok_stall,
    input  wire tok_t tok,
    output logic      push,
    output ent_t      ent,
    input  wire logic q_full
);

    logic       cls_valid_reg, cls_valid_next;
    logic       hdr_pending_reg, hdr_pending_next;
    cls_t       cls_reg, cls_next;

    logic [8:0]  len_c;
    logic [15:0] dist_c;
    logic [4:0]  li, di;
    logic [8:0]  len_diff;
    logic [15:0] dist_diff;
    logic [7:0]  lit_lo;
    logic [8:0]  lit_code, len_code;
    logic        accept;

    logic [WORD_W-1:0]  word;
    logic [NBITS_W-1:0] pos;

    assign tok_stall = cls_valid_reg && q_full;
    assign accept    = tok_valid && !tok_stall;
    assign push      = cls_valid_reg && !q_full;

    // Classify
    always_comb
    begin
        if (tok.match_length < 9'd3)
            len_c = 9'd3;
        else if (tok.match_length > 9'd258)
            len_c = 9'd258;
        else
            len_c = tok.match_length;

        if (tok.match_distance == 16'd0)
            dist_c = 16'd1;
        else if (tok.match_distance > 16'd32768)
            dist_c = 16'd32768;
        else
            dist_c = tok.match_distance;

        li = '0;
        for (int i = 0; i < LEN_N; i++)
        begin
            if (len_c >= LEN_BASE[i])
                li = 5'(i);
        end
        di = '0;
        for (int i = 0; i < DIST_N; i++)
        begin
            if (dist_c >= DIST_BASE[i])
                di = 5'(i);
        end
        len_diff  = len_c - LEN_BASE[li];
        dist_diff = dist_c - DIST_BASE[di];

        lit_lo   = tok.literal_byte - 8'd144;
        // Left-align each code in nine bits so one reversal suits every length
        if (tok.literal_byte <= 8'd143)
            lit_code = {8'(8'h30 + tok.literal_byte), 1'b0};
        else
            lit_code = 9'h190 + {1'b0, lit_lo};
        if (li <= 5'd22)
            len_code = {7'(li + 5'd1), 2'b00};
        else
            len_code = {8'(8'hC0 + {3'b000, li} - 8'd23), 1'b0};

        cls_next           = '0;
        cls_next.hdr       = hdr_pending_reg;
        cls_next.flush     = (tok.op == OP_END);
        case (tok.op)
            OP_LIT:
            begin
                cls_next.sym_rev = rev9(lit_code);
                cls_next.sym_n   = (tok.literal_byte <= 8'd143) ? 4'd8 : 4'd9;
            end
            OP_MATCH:
            begin
                cls_next.sym_rev   = rev9(len_code);
                cls_next.sym_n     = (li <= 5'd22) ? 4'd7 : 4'd8;
                cls_next.lext      = len_diff[4:0];
                cls_next.lext_n    = LEN_EXTRA[li];
                cls_next.has_dist  = 1'b1;
                cls_next.dcode_rev = rev5(di);
                cls_next.dext      = dist_diff[12:0];
                cls_next.dext_n    = DIST_EXTRA[di];
            end
            default:
            begin
                // End of block: symbol 256 is seven zero bits
                cls_next.sym_rev = '0;
                cls_next.sym_n   = 4'd7;
            end
        endcase
    end

    always_comb
    begin
        cls_valid_next   = push ? 1'b0 : cls_valid_reg;
        hdr_pending_next = hdr_pending_reg;
        if (accept && tok.op != OP_NONE)
        begin
            cls_valid_next   = 1'b1;
            hdr_pending_next = (tok.op == OP_END);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg   <= 1'b0;
            hdr_pending_reg <= 1'b1;
        end
        else
        begin
            cls_valid_reg   <= cls_valid_next;
            hdr_pending_reg <= hdr_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && tok.op != OP_NONE)
            cls_reg <= cls_next;
    end

    // Pack: header, code, length extra, distance code, distance extra
    always_comb
    begin
        word = cls_reg.hdr ? WORD_W'(3'b011) : '0;
        pos  = cls_reg.hdr ? NBITS_W'(3) : '0;
        word = word | (WORD_W'(cls_reg.sym_rev) << pos);
        pos  = pos + NBITS_W'(cls_reg.sym_n);
        word = word | (WORD_W'(cls_reg.lext) << pos);
        pos  = pos + NBITS_W'(cls_reg.lext_n);
        if (cls_reg.has_dist)
        begin
            word = word | (WORD_W'(cls_reg.dcode_rev) << pos);
            pos  = pos + NBITS_W'(5);
            word = word | (WORD_W'(cls_reg.dext) << pos);
            pos  = pos + NBITS_W'(cls_reg.dext_n);
        end
        ent.bits  = word;
        ent.nbits = pos;
        ent.flush = cls_reg.flush;
    end

endmodule
`default_nettype wire

>>> rtl/fhtp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhtp_queue
// Short FIFO of packed tokens between the classifier and the byte packer.
// ----------------------------------------------------------------------------
module fhtp_queue
    import fhtp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire ent_t wr_ent,
    input  wire logic pop,
    output ent_t      head,
    output q_stat_t   stat
);

    ent_t              q_mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign stat.full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= wr_ent;
    end

endmodule
`default_nettype wire

>>> rtl/fhtp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhtp_back
// Bit accumulator: loads packed tokens and sends one byte per cycle while res_stall
// is low, padding and flushing the partial byte at end of block.
// ----------------------------------------------------------------------------
module fhtp_back
    import fhtp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire ent_t    head,
    input  wire q_stat_t stat,
    output logic         pop,
    output logic         res_valid,
    input  wire logic    res_stall,
    output res_t         res
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACNT_W-1:0] cnt_reg, cnt_next;
    logic              flush_reg, flush_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              cnt_ge8, pad, have_byte, out_free, emit;
    logic [ACNT_W-1:0] rem;

    assign cnt_ge8   = (cnt_reg >= ACNT_W'(8));
    assign pad       = flush_reg && (cnt_reg != '0) && !cnt_ge8;
    assign have_byte = cnt_ge8 || pad;
    assign out_free  = !res_valid_reg || !res_stall;
    assign emit      = have_byte && out_free;
    assign pop       = !have_byte && !stat.empty;
    assign rem       = cnt_ge8 ? cnt_reg - ACNT_W'(8) : '0;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        flush_next     = flush_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        if (emit)
        begin
            // Bits above the count are always zero, so the pad byte comes for free
            acc_next                = acc_reg >> 8;
            cnt_next                = rem;
            res_valid_next          = 1'b1;
            res_next.out_byte       = acc_reg[7:0];
            res_next.last_of_item   = (rem < ACNT_W'(8)) && !(flush_reg && rem != '0);
            res_next.stream_done    = res_next.last_of_item && flush_reg;
        end
        else if (pop)
        begin
            acc_next   = acc_reg | (ACC_W'(head.bits) << cnt_reg[2:0]);
            cnt_next   = cnt_reg + ACNT_W'(head.nbits);
            flush_next = head.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
`default_nettype wire

>>> rtl/fixed_huffman_token_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_huffman_token_packer_core
// Fixed-Huffman DEFLATE block encoder: literal, match and end tokens in,
// LSB-first packed stream bytes out.
// ----------------------------------------------------------------------------
// Tokens are taken one per cycle, unless the queue is full and tok_stall holds
// them, into a classifier stage and a four-entry queue, so the input keeps
// moving while bytes drain. The byte packer loads a token and then sends each
// byte that it completes, and loads the next token only when it has no byte
// left to send. Op 3 is accepted and dropped. The header is inserted before
// the first token after reset or after an end token; an end token pads and
// flushes the last byte and marks it with stream_done.
module fixed_huffman_token_packer_core
    import fhtp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic tok_valid,
    output logic      tok_stall,
    input  wire tok_t tok,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    logic    push, pop;
    ent_t    wr_ent, head;
    q_stat_t stat;

    fhtp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok),
        .push      (push),
        .ent       (wr_ent),
        .q_full    (stat.full)
    );

    fhtp_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_ent (wr_ent),
        .pop    (pop),
        .head   (head),
        .stat   (stat)
    );

    fhtp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef ASSERT_OFF
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.stream_done |-> res.last_of_item)
        else $error("stream_done without last_of_item");

    a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue full and empty together");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tok_stall |-> stat.full)
        else $error("input stalled with queue room");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
